// ===== src/pite_pkg.sv =====
// ----------------------------------------------------------------------------
// pite_pkg
// Shared types and constants for the per-id threat escalation table.
// ----------------------------------------------------------------------------
package pite_pkg;

    localparam int TableEntries = 1024;
    localparam int IdxW         = $clog2(TableEntries);
    localparam int CntW         = IdxW + 1;

    localparam logic [1:0] LvlClean = 2'd0;
    localparam logic [1:0] LvlSusp  = 2'd1;
    localparam logic [1:0] LvlMal   = 2'd2;
    localparam logic [1:0] LvlThree = 2'd3;

    localparam logic [1:0] RegEscCount  = 2'd0;
    localparam logic [1:0] RegEscWindow = 2'd1;
    localparam logic [1:0] RegDedWindow = 2'd2;

    localparam logic [7:0]  EscCountReset  = 8'd3;
    localparam logic [39:0] EscWindowReset = 40'd10000000000;
    localparam logic [39:0] DedWindowReset = 40'd1000000000;

    typedef struct packed {
        logic [31:0] process_id;
        logic [1:0]  requested_level;
        logic [63:0] time_ns;
    } t_in_word;

    typedef struct packed {
        logic [1:0] effective_level;
        logic       suppressed;
        logic       was_escalated;
    } t_out_word;

    typedef struct packed {
        logic [31:0] key;
        logic [1:0]  last_level;
        logic [7:0]  burst_count;
        logic [63:0] window_start;
        logic [63:0] last_emit;
    } t_slot;

    typedef struct packed {
        logic [7:0]  esc_count;
        logic [39:0] esc_window;
        logic [39:0] ded_window;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_READ,
        ST_UPDATE
    } t_state;

endpackage

// ===== src/pite_regs.sv =====
// ----------------------------------------------------------------------------
// pite_regs
// APB configuration registers for the escalation table.
// ----------------------------------------------------------------------------
module pite_regs
    import pite_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[4:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.esc_count  <= EscCountReset;
            r_cfg.esc_window <= EscWindowReset;
            r_cfg.ded_window <= DedWindowReset;
        end else if (w_wr) begin
            case (w_idx)
                RegEscCount:  r_cfg.esc_count  <= pwdata[7:0];
                RegEscWindow: r_cfg.esc_window <= pwdata[39:0];
                RegDedWindow: r_cfg.ded_window <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            RegEscCount:  prdata = {56'd0, r_cfg.esc_count};
            RegEscWindow: prdata = {24'd0, r_cfg.esc_window};
            RegDedWindow: prdata = {24'd0, r_cfg.ded_window};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== src/pite_core.sv =====
// ----------------------------------------------------------------------------
// pite_core
// Scan sequencer, slot memory and policy update, one slot compared a cycle.
// ----------------------------------------------------------------------------
module pite_core
    import pite_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_word  i_in,
    input  t_cfg      i_cfg,
    output logic      o_busy,
    output logic      o_valid,
    output t_out_word o_out
);

    logic [31:0]             r_keys [TableEntries];
    t_slot                   r_mem  [TableEntries];

    t_state          r_state, n_state;
    t_in_word        r_in;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] r_fill;
    logic [IdxW-1:0] r_slot;
    logic            r_hit;
    logic [31:0]     r_key_rd;
    logic            r_cmp_ok;
    logic [IdxW-1:0] r_cmp_idx;
    t_slot           r_rd;
    logic            r_fresh;
    logic            r_ovalid;
    t_out_word       r_out;

    logic [IdxW-1:0] w_idx;
    logic [1:0]      w_req;
    t_slot           w_cur, w_new;
    logic [1:0]      w_eff;
    logic            w_esc, w_sup;
    logic [63:0]     w_dt;
    logic [8:0]      w_inc;

    assign w_idx = r_cnt[IdxW-1:0];
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_SCAN;
            ST_SCAN:   if (r_hit || (r_cmp_ok && r_cmp_idx == IdxW'(TableEntries - 1)))
                           n_state = ST_PICK;
            ST_PICK:   n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key_rd <= r_keys[w_idx];
        if (r_state == ST_READ) r_rd <= r_mem[r_slot];
        if (r_state == ST_UPDATE) begin
            r_mem[r_slot]  <= w_new;
            r_keys[r_slot] <= r_in.process_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_cmp_ok <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_cnt    <= '0;
                    r_cmp_ok <= 1'b0;
                    r_hit    <= 1'b0;
                    if (i_start) r_in <= i_in;
                end
                ST_SCAN: begin
                    r_cmp_ok  <= !r_cnt[IdxW];
                    r_cmp_idx <= w_idx;
                    if (!r_cnt[IdxW]) r_cnt <= r_cnt + 1'b1;
                    if (r_cmp_ok && !r_hit && ({1'b0, r_cmp_idx} < r_fill) &&
                        r_key_rd == r_in.process_id) begin
                        r_hit  <= 1'b1;
                        r_slot <= r_cmp_idx;
                    end
                end
                ST_PICK: begin
                    r_fresh <= !r_hit;
                    if (!r_hit) begin
                        if (r_fill[IdxW]) begin
                            r_slot <= r_in.process_id[IdxW-1:0];
                        end else begin
                            r_slot <= r_fill[IdxW-1:0];
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                ST_UPDATE: begin
                    r_ovalid        <= 1'b1;
                    r_out           <= '{effective_level: w_eff,
                                         suppressed: w_sup,
                                         was_escalated: w_esc};
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_req = (r_in.requested_level == LvlThree) ? LvlMal : r_in.requested_level;
        w_cur = r_fresh ? t_slot'('0) : r_rd;
        w_new = w_cur;
        w_new.key = r_in.process_id;
        w_eff = w_req;
        w_esc = 1'b0;
        w_dt  = r_in.time_ns - w_cur.window_start;
        w_inc = '0;
        if (w_req == LvlSusp) begin
            if (w_cur.window_start == 64'd0 || w_dt > {24'd0, i_cfg.esc_window}) begin
                w_new.window_start = r_in.time_ns;
                w_new.burst_count  = '0;
            end
            w_inc = {1'b0, w_new.burst_count} + 9'd1;
            if (w_new.burst_count != 8'hFF) w_new.burst_count = w_inc[7:0];
            if (w_new.burst_count >= i_cfg.esc_count) begin
                w_eff = LvlMal;
                w_esc = 1'b1;
            end
        end else begin
            w_new.burst_count  = '0;
            w_new.window_start = r_in.time_ns;
        end
        w_sup = (w_eff == w_cur.last_level) && !w_esc &&
                ((r_in.time_ns - w_cur.last_emit) < {24'd0, i_cfg.ded_window});
        if (!w_sup) begin
            w_new.last_level = w_eff;
            w_new.last_emit  = r_in.time_ns;
        end
    end

    a_valid_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPDATE |=> o_valid) else $error("no result after update");
    a_valid_only_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == ST_UPDATE) else $error("stray result");
    a_esc_mal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.was_escalated |-> o_out.effective_level == LvlMal && !o_out.suppressed)
        else $error("bad escalation");

endmodule

// ===== src/per_id_threat_escalation_table_unit.sv =====
// ----------------------------------------------------------------------------
// per_id_threat_escalation_table_unit
// The scan compares one slot key a cycle, stopping early on a match; the pick,
// read and update states follow it before the result is registered.
// Throughput: one report at a time; busy is high from acceptance until the
// result strobe, and the next report may be accepted in the strobe cycle.
// Reset: synchronous active low; clears the slot fill count and restores registers.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module per_id_threat_escalation_table_unit
    import pite_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_in,
    output logic        o_strobe,
    output t_out_word   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;

    pite_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    pite_core u_core (
        .i_clk, .i_rst_n, .i_start(start), .i_in, .i_cfg(w_cfg),
        .o_busy(busy), .o_valid(o_strobe), .o_out
    );

endmodule
